// ===== src/pih_pkg.sv =====
// Shared types and constants for the per-player input history unit.
// Depends on nothing; every other file refers to it by scoped names.
package pih_pkg;

    localparam int FRAME_W = 16;
    localparam int BITS_W  = 8;
    localparam int PLAYER_FIELD_W = 8;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Work classes that the front hands to the back.
    typedef enum logic [1:0] {
        KIND_STORE = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_MISS  = 2'd2
    } t_kind;

    localparam int KIND_W = 2;

    // Back-end sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== src/pih_queue.sv =====
// Two-entry command queue between the front and the back of the history unit.
// Depends on pih_pkg for its depth constants and status struct.
module pih_queue #(
    parameter int WIDTH = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output pih_pkg::t_q_stat   o_stat
);

    logic [WIDTH-1:0]            r_slot [pih_pkg::QUEUE_DEPTH];
    logic [pih_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [pih_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [pih_pkg::QCNT_W-1:0]  r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_stat.full  = (r_count == pih_pkg::QCNT_W'(pih_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/pih_front.sv =====
// Front end of the history unit: takes items, checks the player range and
// classifies each one. Depends on pih_pkg for the work classes.
module pih_front #(
    parameter int PLAYER_COUNT = 4,
    parameter int PW           = 2,
    parameter int ENTRY_W      = 28
) (
    input  logic                                i_start,
    input  logic                                i_action,
    input  logic [pih_pkg::PLAYER_FIELD_W-1:0]  i_player,
    input  logic [pih_pkg::FRAME_W-1:0]         i_frame,
    input  logic [pih_pkg::BITS_W-1:0]          i_input_bits,
    input  pih_pkg::t_q_stat                    i_q_stat,
    output logic                                o_busy,
    output logic                                o_push,
    output logic [ENTRY_W-1:0]                  o_entry
);

    logic           in_range;
    logic           accept;
    pih_pkg::t_kind kind;

    assign o_busy   = i_q_stat.full;
    assign accept   = i_start && !i_q_stat.full;
    assign in_range = (i_player < pih_pkg::PLAYER_FIELD_W'(PLAYER_COUNT));

    // A store for a player that does not exist is dropped here.
    always_comb begin
        priority if (!i_action) begin
            kind = pih_pkg::KIND_STORE;
        end else if (in_range) begin
            kind = pih_pkg::KIND_QUERY;
        end else begin
            kind = pih_pkg::KIND_MISS;
        end
    end

    assign o_push  = accept && (i_action || in_range);
    assign o_entry = {kind, i_player[PW-1:0], i_frame, i_input_bits};

endmodule

// ===== src/pih_back.sv =====
// Back end of the history unit: writes records into the history memory and
// scans one player's ring per query. Depends on pih_pkg for states and classes.
module pih_back #(
    parameter int PLAYER_COUNT  = 4,
    parameter int HISTORY_DEPTH = 16,
    parameter int PW            = 2,
    parameter int SW            = 4,
    parameter int FW            = 5,
    parameter int ENTRY_W       = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ENTRY_W-1:0]            i_entry,
    input  pih_pkg::t_q_stat              i_q_stat,
    output logic                          o_pop,
    output logic                          o_result_valid,
    output logic                          o_found,
    output logic [pih_pkg::BITS_W-1:0]    o_result_bits
);

    localparam int MEM_DEPTH = PLAYER_COUNT * (2 ** SW);
    localparam int REC_W     = pih_pkg::FRAME_W + pih_pkg::BITS_W;

    // Queue entry fields.
    pih_pkg::t_kind                q_kind;
    logic [PW-1:0]                 q_player;
    logic [pih_pkg::FRAME_W-1:0]   q_frame;
    logic [pih_pkg::BITS_W-1:0]    q_bits;

    assign q_kind   = pih_pkg::t_kind'(i_entry[ENTRY_W-1 -: pih_pkg::KIND_W]);
    assign q_player = i_entry[REC_W +: PW];
    assign q_frame  = i_entry[pih_pkg::BITS_W +: pih_pkg::FRAME_W];
    assign q_bits   = i_entry[pih_pkg::BITS_W-1:0];

    logic [REC_W-1:0]              r_mem [MEM_DEPTH];
    logic [REC_W-1:0]              r_rd_data;
    logic [SW-1:0]                 r_head [PLAYER_COUNT];
    logic [FW-1:0]                 r_fill [PLAYER_COUNT];

    pih_pkg::t_state               r_state;
    pih_pkg::t_state               n_state;
    logic [PW-1:0]                 r_player;
    logic [pih_pkg::FRAME_W-1:0]   r_limit;
    logic [FW-1:0]                 r_idx;
    logic                          r_pend;
    logic                          r_hit;
    logic [pih_pkg::FRAME_W-1:0]   r_best_frame;
    logic [pih_pkg::BITS_W-1:0]    r_best_bits;
    logic                          r_out_valid;
    logic                          r_found;
    logic [pih_pkg::BITS_W-1:0]    r_out_bits;

    logic                          take;
    logic                          wr_en;
    logic                          rd_en;
    logic                          scan_end;
    logic                          miss_now;
    logic                          start_scan;
    logic [PW+SW-1:0]              wr_addr;
    logic [PW+SW-1:0]              rd_addr;
    logic [pih_pkg::FRAME_W-1:0]   rd_frame;
    logic [pih_pkg::BITS_W-1:0]    rd_bits;
    logic                          better;

    assign rd_frame = r_rd_data[pih_pkg::BITS_W +: pih_pkg::FRAME_W];
    assign rd_bits  = r_rd_data[pih_pkg::BITS_W-1:0];
    assign wr_addr  = {q_player, r_head[q_player]};
    assign rd_addr  = {r_player, r_idx[SW-1:0]};
    assign better   = r_pend && (rd_frame <= r_limit) && (!r_hit || rd_frame > r_best_frame);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pih_pkg::ST_IDLE: begin
                if (!i_q_stat.empty && q_kind == pih_pkg::KIND_QUERY) begin
                    n_state = pih_pkg::ST_SCAN;
                end
            end
            pih_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = pih_pkg::ST_IDLE;
                end
            end
            default: n_state = pih_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        take       = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        scan_end   = 1'b0;
        miss_now   = 1'b0;
        start_scan = 1'b0;
        unique case (r_state)
            pih_pkg::ST_IDLE: begin
                take = !i_q_stat.empty;
                if (take) begin
                    unique case (q_kind)
                        pih_pkg::KIND_STORE: wr_en      = 1'b1;
                        pih_pkg::KIND_QUERY: start_scan = 1'b1;
                        default:             miss_now   = 1'b1;
                    endcase
                end
            end
            pih_pkg::ST_SCAN: begin
                rd_en    = (r_idx < r_fill[r_player]);
                scan_end = !rd_en && !r_pend;
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    assign o_pop = take;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {q_frame, q_bits};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (start_scan) begin
            r_player <= q_player;
            r_limit  <= q_frame;
        end
        if (better) begin
            r_best_frame <= rd_frame;
            r_best_bits  <= rd_bits;
        end
        if (scan_end || miss_now) begin
            r_found    <= scan_end && r_hit;
            r_out_bits <= (scan_end && r_hit) ? r_best_bits : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pih_pkg::ST_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < PLAYER_COUNT; p++) begin
                r_head[p] <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pend      <= rd_en;
            r_out_valid <= scan_end || miss_now;
            if (start_scan) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (better) begin
                    r_hit <= 1'b1;
                end
            end
            if (wr_en) begin
                r_head[q_player] <= (r_head[q_player] == SW'(HISTORY_DEPTH - 1))
                                    ? '0 : r_head[q_player] + 1'b1;
                if (r_fill[q_player] != FW'(HISTORY_DEPTH)) begin
                    r_fill[q_player] <= r_fill[q_player] + 1'b1;
                end
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_found        = r_found;
    assign o_result_bits  = r_out_bits;

endmodule

// ===== src/per_player_input_history_unit.sv =====
// Top level of the per-player input history unit.
// Depends on pih_pkg, pih_front, pih_queue and pih_back.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------------
//  item in  | i_start high, o_busy low   | i_action, i_player, i_frame,
//           |                            | i_input_bits
//  result   | o_result_valid, one cycle  | o_found, o_result_bits
//
// A store is written into the history memory as it leaves the queue. A query
// scans the fill slots of its player's ring, where fill is the number of
// records the player has stored (at most HISTORY_DEPTH); the scan reads one
// slot per cycle through the single read port of the history memory.
// An out-of-range query answers in the cycle right after it leaves the queue.
// Reset is synchronous and active low; it empties the queue and clears every
// head and fill count, so no slot counts as written afterwards.
// o_busy rises only when the two-entry queue is full. Results cannot be held
// off: each one is shown for exactly one cycle.
module per_player_input_history_unit #(
    parameter int PLAYER_COUNT  = 4,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_action,
    input  logic [pih_pkg::PLAYER_FIELD_W-1:0]  i_player,
    input  logic [pih_pkg::FRAME_W-1:0]         i_frame,
    input  logic [pih_pkg::BITS_W-1:0]          i_input_bits,
    output logic                                o_result_valid,
    output logic                                o_found,
    output logic [pih_pkg::BITS_W-1:0]          o_result_bits
);

    // Player index width, slot index width and fill-count width.
    localparam int PW = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;
    localparam int SW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    // A queue entry carries the class, the player index, the frame and the bits.
    localparam int ENTRY_W = pih_pkg::KIND_W + PW + pih_pkg::FRAME_W + pih_pkg::BITS_W;

    logic                 push;
    logic                 pop;
    logic [ENTRY_W-1:0]   front_entry;
    logic [ENTRY_W-1:0]   back_entry;
    pih_pkg::t_q_stat     q_stat;

    // The front checks the player number and drops stores for absent players,
    // so the back never sees an index outside the memory.
    pih_front #(
        .PLAYER_COUNT (PLAYER_COUNT),
        .PW           (PW),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .i_start      (i_start),
        .i_action     (i_action),
        .i_player     (i_player),
        .i_frame      (i_frame),
        .i_input_bits (i_input_bits),
        .i_q_stat     (q_stat),
        .o_busy       (o_busy),
        .o_push       (push),
        .o_entry      (front_entry)
    );

    pih_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .i_pop   (pop),
        .o_data  (back_entry),
        .o_stat  (q_stat)
    );

    // The back holds the history memory; the rings fill from slot zero, so the
    // per-player fill count marks exactly which slots hold records.
    pih_back #(
        .PLAYER_COUNT  (PLAYER_COUNT),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PW            (PW),
        .SW            (SW),
        .FW            (FW),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (back_entry),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_result_bits  (o_result_bits)
    );

endmodule
